>>> src/deq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants for the double-ended ring queue: request and status codes,
// field widths and the default capacity.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int VAL_W  = 32;
    localparam int IDX_W  = 7;
    localparam int LEN_W  = 7;
    localparam int REQ_W  = 3;
    localparam int STAT_W = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_GET        = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SET        = 3'd5;
    localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd6;
    localparam logic [REQ_W-1:0] REQ_FIND       = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // position reported by a find that misses
    localparam logic [IDX_W-1:0] POS_ABSENT = 7'h7F;

endpackage : deq_pkg
`default_nettype wire

>>> src/double_ended_ring_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_ring_queue
// Fixed-capacity deque of 32-bit words kept in a ring RAM with head and count.
// ----------------------------------------------------------------------------
// A request is taken when i_start is high and o_busy is low. Exactly one
// result per request is shown for a single cycle with o_done high; the
// receiver cannot stall it, so it must be captured in that cycle. Push, set,
// removal of the last element and failed requests answer in the cycle after
// the transfer; pop and get need the registered read of the ring RAM and
// answer once that read data has been registered into the result. Remove
// shifts the later elements down one RAM entry per cycle and find compares
// one entry per cycle, as the RAM has a single read and a single write port.
// Unwritten RAM entries are never read, so the RAM needs no clearing after reset.
module double_ended_ring_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic [REQ_W-1:0]  i_req_type,
    input  wire logic [VAL_W-1:0]  i_value,
    input  wire logic [IDX_W-1:0]  i_index,
    output logic                   o_done,
    output logic [STAT_W-1:0]      o_status,
    output logic [VAL_W-1:0]       o_value_out,
    output logic [IDX_W-1:0]       o_position,
    output logic [LEN_W-1:0]       o_length
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_FIND  = 2'd3;

    localparam logic [AW:0]   DEPTH_A = (AW+1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [AW:0]   pos);
        logic [AW:0] sum;
        sum = {1'b0, head} + pos;
        if (sum >= DEPTH_A) begin
            sum = sum - DEPTH_A;
        end
        return sum[AW-1:0];
    endfunction

    logic [1:0]        r_state, n_state;
    logic [AW-1:0]     r_head,  n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_pos,   n_pos;
    logic [VAL_W-1:0]  r_val,   n_val;
    logic              r_done,  n_done;
    logic [STAT_W-1:0] r_status, n_status;
    logic [VAL_W-1:0]  r_vout,  n_vout;
    logic [IDX_W-1:0]  r_posout, n_posout;
    logic [LEN_W-1:0]  r_length, n_length;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [VAL_W-1:0]  mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [VAL_W-1:0]  mem_rdata;

    // index resolution, negative index counts from the back
    logic [XW-1:0]     cnt_x;
    logic [XW-1:0]     mag_x;
    logic [XW-1:0]     idx_x;
    logic              idx_ok;
    logic [AW-1:0]     idx_pos;
    logic [CW:0]       idx_inc;
    logic [CW:0]       pos_inc;
    logic              full;
    logic              empty;
    logic [AW-1:0]     head_dec;

    always_comb begin
        cnt_x = XW'(r_count);
        mag_x = XW'(7'(~i_index + 7'd1));
        if (i_index[IDX_W-1]) begin
            idx_ok = (mag_x <= cnt_x);
            idx_x  = cnt_x - mag_x;
        end else begin
            idx_x  = XW'(i_index[IDX_W-2:0]);
            idx_ok = (idx_x < cnt_x);
        end
        idx_pos  = idx_x[AW-1:0];
        idx_inc  = (CW+1)'(idx_pos) + (CW+1)'(1);
        pos_inc  = (CW+1)'(r_pos) + (CW+1)'(1);
        full     = (r_count == DEPTH_C);
        empty    = (r_count == '0);
        head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_pos     = r_pos;
        n_val     = r_val;
        n_done    = 1'b0;
        n_status  = r_status;
        n_vout    = r_vout;
        n_posout  = r_posout;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = i_value;
        mem_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_val    = i_value;
                    n_status = ST_OK;
                    n_vout   = '0;
                    n_posout = '0;
                    case (i_req_type)
                        REQ_PUSH_BACK: begin
                            n_done = 1'b1;
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = f_phys(r_head, (AW+1)'(r_count));
                                n_count   = r_count + CW'(1);
                            end
                        end
                        REQ_PUSH_FRONT: begin
                            n_done = 1'b1;
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = head_dec;
                                n_head    = head_dec;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        REQ_POP_BACK: begin
                            if (empty) begin
                                n_done   = 1'b1;
                                n_status = ST_NONE;
                            end else begin
                                mem_raddr = f_phys(r_head, (AW+1)'(r_count - CW'(1)));
                                n_count   = r_count - CW'(1);
                                n_state   = S_READ;
                            end
                        end
                        REQ_POP_FRONT: begin
                            if (empty) begin
                                n_done   = 1'b1;
                                n_status = ST_NONE;
                            end else begin
                                mem_raddr = r_head;
                                n_head    = f_phys(r_head, (AW+1)'(1));
                                n_count   = r_count - CW'(1);
                                n_state   = S_READ;
                            end
                        end
                        REQ_GET: begin
                            if (idx_ok) begin
                                mem_raddr = f_phys(r_head, (AW+1)'(idx_pos));
                                n_state   = S_READ;
                            end else begin
                                n_done   = 1'b1;
                                n_status = ST_NONE;
                            end
                        end
                        REQ_SET: begin
                            n_done = 1'b1;
                            if (idx_ok) begin
                                mem_we    = 1'b1;
                                mem_waddr = f_phys(r_head, (AW+1)'(idx_pos));
                            end else begin
                                n_status = ST_NONE;
                            end
                        end
                        REQ_REMOVE: begin
                            if (!idx_ok) begin
                                n_done   = 1'b1;
                                n_status = ST_NONE;
                            end else if (idx_inc < {1'b0, r_count}) begin
                                mem_raddr = f_phys(r_head, (AW+1)'(idx_inc));
                                n_pos     = AW'(idx_inc);
                                n_state   = S_SHIFT;
                            end else begin
                                // last element, nothing to move
                                n_done  = 1'b1;
                                n_count = r_count - CW'(1);
                            end
                        end
                        REQ_FIND: begin
                            if (empty) begin
                                n_done   = 1'b1;
                                n_status = ST_NONE;
                                n_posout = POS_ABSENT;
                            end else begin
                                mem_raddr = r_head;
                                n_pos     = '0;
                                n_state   = S_FIND;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = ST_NONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_done  = 1'b1;
                n_vout  = mem_rdata;
                n_state = S_IDLE;
            end
            S_SHIFT: begin
                // entry at r_pos moves down one place while the next one is read
                mem_we    = 1'b1;
                mem_waddr = f_phys(r_head, (AW+1)'(r_pos - AW'(1)));
                mem_wdata = mem_rdata;
                if (pos_inc < {1'b0, r_count}) begin
                    mem_raddr = f_phys(r_head, (AW+1)'(pos_inc));
                    n_pos     = AW'(pos_inc);
                end else begin
                    n_done  = 1'b1;
                    n_count = r_count - CW'(1);
                    n_state = S_IDLE;
                end
            end
            S_FIND: begin
                if (mem_rdata == r_val) begin
                    n_done   = 1'b1;
                    n_posout = IDX_W'(XW'(r_pos));
                    n_state  = S_IDLE;
                end else if (pos_inc < {1'b0, r_count}) begin
                    mem_raddr = f_phys(r_head, (AW+1)'(pos_inc));
                    n_pos     = AW'(pos_inc);
                end else begin
                    n_done   = 1'b1;
                    n_status = ST_NONE;
                    n_posout = POS_ABSENT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_length = LEN_W'(XW'(n_count));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_status <= n_status;
        r_vout   <= n_vout;
        r_posout <= n_posout;
        r_length <= n_length;
    end

    deq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_value_out = r_vout;
    assign o_position  = r_posout;
    assign o_length    = r_length;

endmodule : double_ended_ring_queue
`default_nettype wire

>>> src/deq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : deq_ram
`default_nettype wire

>>> src/deq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks of the double-ended ring queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker
    import deq_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_start,
    input wire logic              o_busy,
    input wire logic              o_done,
    input wire logic [STAT_W-1:0] o_status,
    input wire logic [VAL_W-1:0]  o_value_out,
    input wire logic [IDX_W-1:0]  o_position
);

    // a result only ever answers a transfer or a request still in flight
    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start || o_busy))
        else $error("result without a request");

    a_fail_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_value_out == '0))
        else $error("failed request returned a value");

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_FULL) |-> (o_position == '0))
        else $error("full push reported a position");

    // a miss reports either zero or the absent marker
    a_none_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_NONE && o_position != '0)
            |-> (o_position == POS_ABSENT))
        else $error("failed request reported a stray position");

endmodule : deq_checker

bind double_ended_ring_queue deq_checker u_deq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_done      (o_done),
    .o_status    (o_status),
    .o_value_out (o_value_out),
    .o_position  (o_position)
);
`default_nettype wire
